### sv/rrss_pkg.sv
// Package for the round-robin slice scheduler: sizes, the controller state type
// and the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package rrss_pkg;

    localparam int MAX_PROCS = 16;
    localparam int SLOT_W    = $clog2(MAX_PROCS);
    localparam int NUM_W     = SLOT_W + 1;

    localparam int TIME_W    = 12;
    localparam int CLK_W     = 17;
    localparam int CNT_W     = 5;
    localparam int PIDX_W    = 4;

    localparam logic [CLK_W-1:0] CLOCK_MAX = 17'h1FFFF;
    localparam logic [CNT_W-1:0] DONE_MAX  = 5'd31;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    localparam logic REG_QUANTUM = 1'b0;
    localparam logic REG_COUNT   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_RUN,
        ST_TAT,
        ST_OUT,
        ST_EMPTY
    } t_state;

    typedef struct packed {
        logic load_slot;
        logic start_scan;
        logic scan_step;
        logic pick;
        logic commit_run;
        logic calc_tat;
        logic load_out;
        logic load_empty;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic scan_last;
        logic pending;
    } t_sts;

endpackage

`default_nettype wire

### sv/rrss_ctrl.sv
// Controller state machine of the round-robin slice scheduler.
// Depends on rrss_pkg; drives rrss_dp through t_cmd and reads t_sts.
`default_nettype none

module rrss_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_op,
    input  wire logic          i_out_stall,
    input  wire rrss_pkg::t_sts i_sts,
    output rrss_pkg::t_cmd     o_cmd,
    output logic               o_in_stall,
    output logic               o_out_valid
);

    rrss_pkg::t_state r_state;
    rrss_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_accept;
    logic             w_free;

    assign w_accept = i_in_valid && (r_state == rrss_pkg::ST_IDLE);
    // The result register can take a new transaction when empty or being drained.
    assign w_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rrss_pkg::ST_IDLE: begin
                if (w_accept && (i_op == rrss_pkg::OP_RUN)) begin
                    n_state = rrss_pkg::ST_SCAN;
                end
            end
            rrss_pkg::ST_SCAN: begin
                if (i_sts.n_zero || i_sts.scan_last) begin
                    n_state = rrss_pkg::ST_PICK;
                end
            end
            rrss_pkg::ST_PICK: begin
                n_state = i_sts.pending ? rrss_pkg::ST_RUN : rrss_pkg::ST_EMPTY;
            end
            rrss_pkg::ST_RUN: begin
                n_state = rrss_pkg::ST_TAT;
            end
            rrss_pkg::ST_TAT: begin
                n_state = rrss_pkg::ST_OUT;
            end
            rrss_pkg::ST_OUT, rrss_pkg::ST_EMPTY: begin
                if (w_free) begin
                    n_state = rrss_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rrss_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            rrss_pkg::ST_IDLE: begin
                o_cmd.load_slot  = w_accept && (i_op == rrss_pkg::OP_LOAD);
                o_cmd.start_scan = w_accept && (i_op == rrss_pkg::OP_RUN);
            end
            rrss_pkg::ST_SCAN: begin
                o_cmd.scan_step = !i_sts.n_zero;
            end
            rrss_pkg::ST_PICK: begin
                o_cmd.pick = 1'b1;
            end
            rrss_pkg::ST_RUN: begin
                o_cmd.commit_run = 1'b1;
            end
            rrss_pkg::ST_TAT: begin
                o_cmd.calc_tat = 1'b1;
            end
            rrss_pkg::ST_OUT: begin
                o_cmd.load_out = w_free;
            end
            rrss_pkg::ST_EMPTY: begin
                o_cmd.load_empty = w_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.load_out || o_cmd.load_empty) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrss_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != rrss_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

    // A waiting result is never overwritten by the next one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_out || o_cmd.load_empty) |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten while stalled");

    // With no active slots the scan takes no step and goes straight to the pick state.
    a_empty_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrss_pkg::ST_SCAN && i_sts.n_zero) |=> (r_state == rrss_pkg::ST_PICK))
        else $error("scan with no active slots did not end");

    // A finished result that cannot drain keeps the controller in its output state.
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrss_pkg::ST_OUT && !w_free) |=> (r_state == rrss_pkg::ST_OUT))
        else $error("output state left while result register busy");

endmodule

`default_nettype wire

### sv/rrss_dp.sv
// Datapath of the round-robin slice scheduler: slot tables, clock, scan trackers
// and the result register. Depends on rrss_pkg; steered by rrss_ctrl.
`default_nettype none

module rrss_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rrss_pkg::t_cmd                i_cmd,
    output rrss_pkg::t_sts                     o_sts,
    input  wire logic [rrss_pkg::PIDX_W-1:0]   i_slot_index,
    input  wire logic [rrss_pkg::TIME_W-1:0]   i_burst_time,
    input  wire logic [rrss_pkg::TIME_W-1:0]   i_arrival_time,
    input  wire logic [rrss_pkg::TIME_W-1:0]   i_cfg_quantum,
    input  wire logic [rrss_pkg::CNT_W-1:0]    i_cfg_count,
    output logic [rrss_pkg::PIDX_W-1:0]        o_process_index,
    output logic [rrss_pkg::CLK_W-1:0]         o_slice_start,
    output logic [rrss_pkg::CLK_W-1:0]         o_slice_end,
    output logic                               o_finished,
    output logic [rrss_pkg::CLK_W-1:0]         o_turnaround,
    output logic [rrss_pkg::CLK_W-1:0]         o_waiting,
    output logic                               o_idle_jump,
    output logic                               o_all_done
);

    localparam int SW = rrss_pkg::SLOT_W;
    localparam int NW = rrss_pkg::NUM_W;
    localparam int TW = rrss_pkg::TIME_W;
    localparam int CW = rrss_pkg::CLK_W;

    // Slot tables, one read address (r_idx) shared by all phases.
    logic [TW-1:0] r_rem [rrss_pkg::MAX_PROCS];
    logic [TW-1:0] r_arr [rrss_pkg::MAX_PROCS];
    logic [TW-1:0] r_bst [rrss_pkg::MAX_PROCS];

    logic [SW-1:0]             r_ptr;
    logic [CW-1:0]             r_clk;
    logic [rrss_pkg::CNT_W-1:0] r_cnt;

    logic [NW-1:0] r_n;
    logic [NW-1:0] r_k;
    logic [SW-1:0] r_idx;
    logic          r_pending;
    logic          r_ready;
    logic [SW-1:0] r_first_rdy;
    logic [TW-1:0] r_min_arr;
    logic [SW-1:0] r_min_idx;
    logic          r_idle;
    logic [CW-1:0] r_start;
    logic          r_fin;
    logic [CW-1:0] r_tat;

    logic [rrss_pkg::PIDX_W-1:0] r_o_pidx;
    logic [CW-1:0]               r_o_start;
    logic [CW-1:0]               r_o_end;
    logic                        r_o_fin;
    logic [CW-1:0]               r_o_tat;
    logic [CW-1:0]               r_o_wt;
    logic                        r_o_idle;
    logic                        r_o_alld;

    logic [TW-1:0] w_rem;
    logic [TW-1:0] w_arr;
    logic [TW-1:0] w_bst;
    logic          w_live;
    logic          w_rdy;
    logic [NW-1:0] w_n;
    logic [SW-1:0] w_start;
    logic [NW-1:0] w_idx_p1;
    logic [TW-1:0] w_q;
    logic          w_q_lt;
    logic [TW-1:0] w_run;
    logic [CW:0]   w_sum;
    logic [CW-1:0] w_wt;
    logic          w_slot_ok;

    assign w_rem  = r_rem[r_idx];
    assign w_arr  = r_arr[r_idx];
    assign w_bst  = r_bst[r_idx];
    assign w_live = (w_rem != '0);
    assign w_rdy  = w_live && (CW'(w_arr) <= r_clk);

    assign w_n = (32'(i_cfg_count) > rrss_pkg::MAX_PROCS) ?
                 NW'(rrss_pkg::MAX_PROCS) : NW'(i_cfg_count);
    assign w_start  = (NW'(r_ptr) < w_n) ? r_ptr : '0;
    assign w_idx_p1 = NW'(r_idx) + NW'(1);

    assign w_q    = (i_cfg_quantum == '0) ? TW'(1) : i_cfg_quantum;
    assign w_q_lt = (w_q < w_rem);
    assign w_run  = w_q_lt ? w_q : w_rem;
    assign w_sum  = {1'b0, r_clk} + (CW + 1)'(w_run);
    assign w_wt   = (r_tat > CW'(w_bst)) ? (r_tat - CW'(w_bst)) : '0;

    assign w_slot_ok = (32'(i_slot_index) < rrss_pkg::MAX_PROCS);

    assign o_sts.n_zero    = (r_n == '0);
    assign o_sts.scan_last = ((r_k + NW'(1)) == r_n);
    assign o_sts.pending   = r_pending;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_slot && w_slot_ok) begin
            r_rem[SW'(i_slot_index)] <= i_burst_time;
            r_arr[SW'(i_slot_index)] <= i_arrival_time;
            r_bst[SW'(i_slot_index)] <= i_burst_time;
        end else if (i_cmd.commit_run) begin
            r_rem[r_idx] <= w_rem - w_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_clk     <= '0;
            r_cnt     <= '0;
            r_pending <= 1'b0;
            r_ready   <= 1'b0;
            r_idle    <= 1'b0;
        end else begin
            if (i_cmd.load_slot) begin
                r_ptr <= '0;
                r_clk <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.start_scan) begin
                r_n       <= w_n;
                r_k       <= '0;
                r_idx     <= w_start;
                r_pending <= 1'b0;
                r_ready   <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (w_live && !r_ready && w_rdy) begin
                    r_ready     <= 1'b1;
                    r_first_rdy <= r_idx;
                end
                // Strict compare keeps the first slot in scan order on a tie.
                if (w_live && (!r_pending || (w_arr < r_min_arr))) begin
                    r_min_arr <= w_arr;
                    r_min_idx <= r_idx;
                end
                if (w_live) begin
                    r_pending <= 1'b1;
                end
                r_idx <= (w_idx_p1 == r_n) ? '0 : w_idx_p1[SW-1:0];
                r_k   <= r_k + NW'(1);
            end
            if (i_cmd.pick && r_pending) begin
                // When nothing has arrived, the clock jumps to the earliest
                // arrival, and the first slot holding it is the one that runs.
                if (r_ready) begin
                    r_idx  <= r_first_rdy;
                    r_idle <= 1'b0;
                end else begin
                    r_idx  <= r_min_idx;
                    r_clk  <= CW'(r_min_arr);
                    r_idle <= 1'b1;
                end
            end
            if (i_cmd.commit_run) begin
                r_start <= r_clk;
                r_clk   <= (w_sum > (CW + 1)'(rrss_pkg::CLOCK_MAX)) ?
                           rrss_pkg::CLOCK_MAX : w_sum[CW-1:0];
                r_fin   <= !w_q_lt;
                r_ptr   <= (w_idx_p1 >= r_n) ? '0 : w_idx_p1[SW-1:0];
                if (!w_q_lt && (r_cnt != rrss_pkg::DONE_MAX)) begin
                    r_cnt <= r_cnt + rrss_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_tat) begin
            r_tat <= (r_clk > CW'(w_arr)) ? (r_clk - CW'(w_arr)) : '0;
        end
        if (i_cmd.load_out) begin
            r_o_pidx  <= rrss_pkg::PIDX_W'(r_idx);
            r_o_start <= r_start;
            r_o_end   <= r_clk;
            r_o_fin   <= r_fin;
            r_o_tat   <= r_fin ? r_tat : '0;
            r_o_wt    <= r_fin ? w_wt : '0;
            r_o_idle  <= r_idle;
            r_o_alld  <= 1'b0;
        end else if (i_cmd.load_empty) begin
            r_o_pidx  <= '0;
            r_o_start <= r_clk;
            r_o_end   <= r_clk;
            r_o_fin   <= 1'b0;
            r_o_tat   <= '0;
            r_o_wt    <= '0;
            r_o_idle  <= 1'b0;
            r_o_alld  <= 1'b1;
        end
    end

    assign o_process_index = r_o_pidx;
    assign o_slice_start   = r_o_start;
    assign o_slice_end     = r_o_end;
    assign o_finished      = r_o_fin;
    assign o_turnaround    = r_o_tat;
    assign o_waiting       = r_o_wt;
    assign o_idle_jump     = r_o_idle;
    assign o_all_done      = r_o_alld;

    // The clock never moves backward across a slice.
    a_clk_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit_run |=> (r_clk >= $past(r_clk)))
        else $error("clock moved backward during a slice");

    // After a slice the pointer lies inside the active range.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit_run |=> ((NW'(r_ptr) < r_n) || (r_ptr == '0)))
        else $error("scan pointer outside active slots");

    // A slot is only run when it was found live during the scan.
    a_run_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit_run |-> (r_pending && w_live))
        else $error("slice run on a finished slot");

endmodule

`default_nettype wire

### sv/round_robin_slice_scheduler.sv
// Top level of the round-robin slice scheduler: configuration registers on an
// APB-style port, plus rrss_ctrl and rrss_dp. Depends on rrss_pkg.
//
// Usage. Input transactions carry an op bit. A load transaction (op 0) stores one slot's
// burst and arrival time and restarts the schedule: clock, scan pointer and completion
// tally go to zero. It produces no result. A run transaction (op 1)
// produces one result transaction: the slot that ran, the slice start and end times, and
// on completion the turnaround and waiting times. If no active slot has arrived yet, the
// clock first jumps to the earliest arrival and idle_jump is set. If every active slot is
// finished, the result has all_done set and no slice is run.
// Flow. The scan walks the slot tables one entry per cycle (the scan state is entered even
// with no active slot), then the controller picks the slot, commits the slice, forms the
// turnaround and loads the result in its output step, in that order. An all_done result
// skips the commit and turnaround steps. The input stalls while a run is in work, so the
// next transaction is taken only once the result is loaded. A stalled receiver does not
// block the next input, but a finished run waits in its output step until the output
// register drains. Reset (synchronous, active low) clears clock, pointer, tally and
// handshake state and sets quantum and slot count to one; slot tables are undefined
// until loaded. Configuration is to be written by the user only while idle; the block
// itself does not enforce it.
`default_nettype none

module round_robin_slice_scheduler (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // Input channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_op,
    input  wire logic [rrss_pkg::PIDX_W-1:0]  i_slot_index,
    input  wire logic [rrss_pkg::TIME_W-1:0]  i_burst_time,
    input  wire logic [rrss_pkg::TIME_W-1:0]  i_arrival_time,
    // Output channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [rrss_pkg::PIDX_W-1:0]       o_process_index,
    output logic [rrss_pkg::CLK_W-1:0]        o_slice_start,
    output logic [rrss_pkg::CLK_W-1:0]        o_slice_end,
    output logic                              o_finished,
    output logic [rrss_pkg::CLK_W-1:0]        o_turnaround,
    output logic [rrss_pkg::CLK_W-1:0]        o_waiting,
    output logic                              o_idle_jump,
    output logic                              o_all_done
);

    logic [rrss_pkg::TIME_W-1:0] r_quantum;
    logic [rrss_pkg::CNT_W-1:0]  r_count;
    logic                        w_wr;
    rrss_pkg::t_cmd              w_cmd;
    rrss_pkg::t_sts              w_sts;

    // The register index is address bit 2; the two low bits select a byte lane
    // and are ignored.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= rrss_pkg::TIME_W'(1);
            r_count   <= rrss_pkg::CNT_W'(1);
        end else if (w_wr) begin
            case (paddr[2])
                rrss_pkg::REG_QUANTUM: begin
                    r_quantum <= pwdata[rrss_pkg::TIME_W-1:0];
                end
                rrss_pkg::REG_COUNT: begin
                    r_count <= pwdata[rrss_pkg::CNT_W-1:0];
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            rrss_pkg::REG_QUANTUM: prdata = 32'(r_quantum);
            rrss_pkg::REG_COUNT:   prdata = 32'(r_count);
            default:               prdata = '0;
        endcase
    end

    rrss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    rrss_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_slot_index    (i_slot_index),
        .i_burst_time    (i_burst_time),
        .i_arrival_time  (i_arrival_time),
        .i_cfg_quantum   (r_quantum),
        .i_cfg_count     (r_count),
        .o_process_index (o_process_index),
        .o_slice_start   (o_slice_start),
        .o_slice_end     (o_slice_end),
        .o_finished      (o_finished),
        .o_turnaround    (o_turnaround),
        .o_waiting       (o_waiting),
        .o_idle_jump     (o_idle_jump),
        .o_all_done      (o_all_done)
    );

endmodule

`default_nettype wire

### verif/tb_round_robin_slice_scheduler.sv
// Self-checking testbench for round_robin_slice_scheduler: a scripted opening, then random
// phases, each result checked against a scripted value or a cycle-free scheduling predictor.
// Depends on rrss_pkg and the round_robin_slice_scheduler RTL.
`timescale 1ns / 100ps

module tb_round_robin_slice_scheduler;

    localparam int MAX_PROCS = rrss_pkg::MAX_PROCS;
    localparam int SLOT_W    = rrss_pkg::SLOT_W;
    localparam int TIME_W    = rrss_pkg::TIME_W;
    localparam int CLK_W     = rrss_pkg::CLK_W;
    localparam int CNT_W     = rrss_pkg::CNT_W;
    localparam int PIDX_W    = rrss_pkg::PIDX_W;

    // Pause after the last expected result before touching configuration or ending the run.
    // It is long enough to cover one run transaction still in flight.
    localparam int SETTLE_CYCLES = 30;
    // Cycles with no transaction on any port before the run is declared hung.
    localparam int QUIET_LIMIT   = 3000;
    // Length of the receiver hold-off that backs the block up into its input.
    localparam int HOLD_CYCLES   = 300;
    localparam int ITEM_TARGET   = 700;
    localparam int MAX_REPORTS   = 40;

    // Sender idle and receiver stall percentages, one pair per phase, used in rotation.
    localparam int SEND_IDLE_PCT [4] = '{0, 49, 0, 35};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 49, 35};

    typedef struct packed {
        logic              op;
        logic [PIDX_W-1:0] slot_index;
        logic [TIME_W-1:0] burst_time;
        logic [TIME_W-1:0] arrival_time;
    } t_sched_item;

    typedef struct packed {
        logic [PIDX_W-1:0] process_index;
        logic [CLK_W-1:0]  slice_start;
        logic [CLK_W-1:0]  slice_end;
        logic              finished;
        logic [CLK_W-1:0]  turnaround;
        logic [CLK_W-1:0]  waiting;
        logic              idle_jump;
        logic              all_done;
    } t_slice_result;

    typedef enum logic {
        ROW_ITEM,
        ROW_CONFIG
    } t_row_kind;

    // One line of the opening script. A config row writes reg_index with reg_value once the
    // block is idle. An item row sends item; when typed is set, slice is the result expected
    // for it, otherwise the predictor supplies the expectation.
    typedef struct packed {
        t_row_kind     kind;
        logic          reg_index;
        logic [11:0]   reg_value;
        t_sched_item   item;
        logic          typed;
        t_slice_result slice;
    } t_script_row;

    localparam int NUM_SCRIPT_ROWS = 20;

    // The script starts from reset (quantum 1, one slot). It covers a single slot finishing
    // at once, the all-finished answer, the clock jumping to a late arrival, the widest
    // quantum and burst, the highest slot number, and two slots sharing the processor.
    localparam t_script_row OPENING_SCRIPT [NUM_SCRIPT_ROWS] = '{
        '{ROW_ITEM, rrss_pkg::REG_QUANTUM, 12'd0, '{rrss_pkg::OP_LOAD, 4'd0, 12'd1, 12'd0},
          1'b0, '0},
        '{ROW_ITEM, rrss_pkg::REG_QUANTUM, 12'd0, '{rrss_pkg::OP_RUN, 4'd0, 12'd0, 12'd0},
          1'b1, '{4'd0, 17'd0, 17'd1, 1'b1, 17'd1, 17'd0, 1'b0, 1'b0}},
        '{ROW_ITEM, rrss_pkg::REG_QUANTUM, 12'd0, '{rrss_pkg::OP_RUN, 4'd0, 12'd0, 12'd0},
          1'b1, '{4'd0, 17'd1, 17'd1, 1'b0, 17'd0, 17'd0, 1'b0, 1'b1}},
        '{ROW_ITEM, rrss_pkg::REG_QUANTUM, 12'd0, '{rrss_pkg::OP_LOAD, 4'd0, 12'd2, 12'd4095},
          1'b0, '0},
        '{ROW_ITEM, rrss_pkg::REG_QUANTUM, 12'd0, '{rrss_pkg::OP_RUN, 4'd0, 12'd0, 12'd0},
          1'b1, '{4'd0, 17'd4095, 17'd4096, 1'b0, 17'd0, 17'd0, 1'b1, 1'b0}},
        '{ROW_ITEM, rrss_pkg::REG_QUANTUM, 12'd0, '{rrss_pkg::OP_RUN, 4'd0, 12'd0, 12'd0},
          1'b1, '{4'd0, 17'd4096, 17'd4097, 1'b1, 17'd2, 17'd0, 1'b0, 1'b0}},
        '{ROW_ITEM, rrss_pkg::REG_QUANTUM, 12'd0, '{rrss_pkg::OP_RUN, 4'd0, 12'd0, 12'd0},
          1'b1, '{4'd0, 17'd4097, 17'd4097, 1'b0, 17'd0, 17'd0, 1'b0, 1'b1}},
        '{ROW_ITEM, rrss_pkg::REG_QUANTUM, 12'd0, '{rrss_pkg::OP_LOAD, 4'd15, 12'd4095, 12'd0},
          1'b0, '0},
        '{ROW_CONFIG, rrss_pkg::REG_QUANTUM, 12'd4095, '0, 1'b0, '0},
        '{ROW_ITEM, rrss_pkg::REG_QUANTUM, 12'd0, '{rrss_pkg::OP_LOAD, 4'd0, 12'd4095, 12'd0},
          1'b0, '0},
        '{ROW_ITEM, rrss_pkg::REG_QUANTUM, 12'd0, '{rrss_pkg::OP_RUN, 4'd0, 12'd0, 12'd0},
          1'b1, '{4'd0, 17'd0, 17'd4095, 1'b1, 17'd4095, 17'd0, 1'b0, 1'b0}},
        '{ROW_CONFIG, rrss_pkg::REG_QUANTUM, 12'd3, '0, 1'b0, '0},
        '{ROW_CONFIG, rrss_pkg::REG_COUNT, 12'd2, '0, 1'b0, '0},
        '{ROW_ITEM, rrss_pkg::REG_QUANTUM, 12'd0, '{rrss_pkg::OP_LOAD, 4'd1, 12'd5, 12'd2},
          1'b0, '0},
        '{ROW_ITEM, rrss_pkg::REG_QUANTUM, 12'd0, '{rrss_pkg::OP_LOAD, 4'd0, 12'd4, 12'd0},
          1'b0, '0},
        '{ROW_ITEM, rrss_pkg::REG_QUANTUM, 12'd0, '{rrss_pkg::OP_RUN, 4'd0, 12'd0, 12'd0},
          1'b0, '0},
        '{ROW_ITEM, rrss_pkg::REG_QUANTUM, 12'd0, '{rrss_pkg::OP_RUN, 4'd0, 12'd0, 12'd0},
          1'b0, '0},
        '{ROW_ITEM, rrss_pkg::REG_QUANTUM, 12'd0,
          '{rrss_pkg::OP_RUN, 4'd15, 12'd4095, 12'd4095}, 1'b0, '0},
        '{ROW_ITEM, rrss_pkg::REG_QUANTUM, 12'd0, '{rrss_pkg::OP_RUN, 4'd0, 12'd0, 12'd0},
          1'b0, '0},
        '{ROW_ITEM, rrss_pkg::REG_QUANTUM, 12'd0, '{rrss_pkg::OP_RUN, 4'd0, 12'd0, 12'd0},
          1'b1, '{4'd0, 17'd9, 17'd9, 1'b0, 17'd0, 17'd0, 1'b0, 1'b1}}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_op;
    logic [PIDX_W-1:0]   i_slot_index;
    logic [TIME_W-1:0]   i_burst_time;
    logic [TIME_W-1:0]   i_arrival_time;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [PIDX_W-1:0]   o_process_index;
    logic [CLK_W-1:0]    o_slice_start;
    logic [CLK_W-1:0]    o_slice_end;
    logic                o_finished;
    logic [CLK_W-1:0]    o_turnaround;
    logic [CLK_W-1:0]    o_waiting;
    logic                o_idle_jump;
    logic                o_all_done;

    // Predictor state: a private copy of the scheduler's slot tables, clock and registers.
    logic [TIME_W-1:0]   slot_remaining [MAX_PROCS];
    logic [TIME_W-1:0]   slot_arrival   [MAX_PROCS];
    logic [TIME_W-1:0]   slot_burst     [MAX_PROCS];
    logic [MAX_PROCS-1:0] slot_loaded   = '0;
    logic [SLOT_W-1:0]   scan_ptr       = '0;
    logic [CLK_W-1:0]    sched_clock    = '0;
    logic [CNT_W-1:0]    done_tally     = '0;
    logic [TIME_W-1:0]   quantum_reg    = TIME_W'(1);
    logic [CNT_W-1:0]    count_reg      = CNT_W'(1);

    // Slices predicted for accepted run transactions, oldest first.
    t_slice_result       pending_slices [$];

    int                  fail_count      = 0;
    int                  items_sent      = 0;
    int                  quiet_cycles    = 0;
    int                  sender_idle_pct = 0;
    int                  recv_stall_pct  = 0;
    int                  hold_requests   = 0;
    int                  holds_served    = 0;

    round_robin_slice_scheduler DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_slot_index    (i_slot_index),
        .i_burst_time    (i_burst_time),
        .i_arrival_time  (i_arrival_time),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_process_index (o_process_index),
        .o_slice_start   (o_slice_start),
        .o_slice_end     (o_slice_end),
        .o_finished      (o_finished),
        .o_turnaround    (o_turnaround),
        .o_waiting       (o_waiting),
        .o_idle_jump     (o_idle_jump),
        .o_all_done      (o_all_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one accepted transaction to the predictor. A load rewrites one slot and
    // restarts the schedule; a run picks the next ready slot round robin and returns the
    // slice it would get. The return value says whether a result is due.
    function automatic bit predict_slice(input t_sched_item item, output t_slice_result slice);
        int unsigned n;
        int unsigned idx;
        int unsigned first;
        int unsigned sel;
        int unsigned earliest;
        int unsigned q;
        int unsigned run_len;
        int unsigned next_clock;
        int unsigned tat;
        bit          any_pending;
        bit          any_ready;
        bit          found;
        slice = '0;
        any_pending = 1'b0;
        any_ready = 1'b0;
        found = 1'b0;
        if (item.op == rrss_pkg::OP_LOAD) begin
            slot_burst[item.slot_index] = item.burst_time;
            slot_arrival[item.slot_index] = item.arrival_time;
            slot_remaining[item.slot_index] = item.burst_time;
            slot_loaded[item.slot_index] = 1'b1;
            sched_clock = '0;
            scan_ptr = '0;
            done_tally = '0;
            return 1'b0;
        end

        n = (32'(count_reg) > MAX_PROCS) ? MAX_PROCS : 32'(count_reg);
        earliest = 32'(rrss_pkg::CLOCK_MAX);
        for (idx = 0; idx < n; idx++) begin
            if (slot_remaining[idx] != 0) begin
                any_pending = 1'b1;
                if (CLK_W'(slot_arrival[idx]) <= sched_clock)
                    any_ready = 1'b1;
                if (32'(slot_arrival[idx]) < earliest)
                    earliest = 32'(slot_arrival[idx]);
            end
        end

        // Nothing left to run: report the current clock and leave every table alone.
        if (!any_pending) begin
            slice.slice_start = sched_clock;
            slice.slice_end = sched_clock;
            slice.all_done = 1'b1;
            return 1'b1;
        end

        // No unfinished slot has arrived yet, so time skips ahead to the first arrival.
        if (!any_ready) begin
            sched_clock = CLK_W'(earliest);
            slice.idle_jump = 1'b1;
        end

        // A pointer left beyond the active slots (after the count shrank) restarts at zero.
        first = (32'(scan_ptr) < n) ? 32'(scan_ptr) : 0;
        sel = first;
        for (idx = 0; idx < n; idx++) begin
            if (!found && slot_remaining[(first + idx) % n] != 0 &&
                    CLK_W'(slot_arrival[(first + idx) % n]) <= sched_clock) begin
                sel = (first + idx) % n;
                found = 1'b1;
            end
        end

        q = (quantum_reg == 0) ? 1 : 32'(quantum_reg);
        run_len = (q < 32'(slot_remaining[sel])) ? q : 32'(slot_remaining[sel]);
        slice.process_index = PIDX_W'(sel);
        slice.slice_start = sched_clock;
        next_clock = 32'(sched_clock) + run_len;
        sched_clock = (next_clock > 32'(rrss_pkg::CLOCK_MAX)) ? rrss_pkg::CLOCK_MAX
                                                              : CLK_W'(next_clock);
        slice.slice_end = sched_clock;
        slot_remaining[sel] = slot_remaining[sel] - TIME_W'(run_len);
        scan_ptr = (sel + 1 >= n) ? '0 : SLOT_W'(sel + 1);

        if (slot_remaining[sel] == 0) begin
            slice.finished = 1'b1;
            if (done_tally < rrss_pkg::DONE_MAX)
                done_tally = done_tally + CNT_W'(1);
            tat = (32'(sched_clock) > 32'(slot_arrival[sel])) ?
                  32'(sched_clock) - 32'(slot_arrival[sel]) : 0;
            slice.turnaround = CLK_W'(tat);
            slice.waiting = (tat > 32'(slot_burst[sel])) ?
                            CLK_W'(tat - 32'(slot_burst[sel])) : '0;
        end
        return 1'b1;
    endfunction

    // Builds a load transaction. Most bursts are at most bmax and most arrivals at most amax, so
    // schedules finish in a few dozen slices; each field takes its full range one time in sixteen.
    function automatic t_sched_item make_load(input int unsigned slot, input int unsigned bmax,
                                              input int unsigned amax);
        t_sched_item item;
        item.op = rrss_pkg::OP_LOAD;
        item.slot_index = PIDX_W'(slot);
        item.burst_time = TIME_W'($urandom_range(1, ($urandom_range(15) == 0) ? 4095 : bmax));
        item.arrival_time = TIME_W'($urandom_range(0, ($urandom_range(15) == 0) ? 4095 : amax));
        return item;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Offers one input transaction, holds it until accepted, then records what it predicts.
    // Idle cycles are only chosen before valid goes up, so valid never follows stall.
    task automatic send_item(input t_sched_item item, input bit typed,
                             input t_slice_result typed_slice);
        t_slice_result slice;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= item.op;
        i_slot_index   <= item.slot_index;
        i_burst_time   <= item.burst_time;
        i_arrival_time <= item.arrival_time;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        items_sent++;
        if (predict_slice(item, slice))
            pending_slices.push_back(typed ? typed_slice : slice);
    endtask

    // Waits until every predicted slice has come out, then lets the block finish any load
    // or run still inside it. Configuration may change only after this.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_slices.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register through a setup and an access cycle, then reads it back. The port
    // is then left idle so that the next access starts on a fresh edge.
    task automatic write_register(input logic reg_index, input logic [31:0] value);
        logic [31:0] stored;
        stored = (reg_index == rrss_pkg::REG_QUANTUM) ? {20'd0, value[TIME_W-1:0]}
                                                      : {27'd0, value[CNT_W-1:0]};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (reg_index == rrss_pkg::REG_QUANTUM)
            quantum_reg = value[TIME_W-1:0];
        else
            count_reg = value[CNT_W-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        check_field("register readback", stored, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result side. Every accepted result transaction is compared field by field with the
    // oldest prediction. Outputs are read at the edge itself, before this edge's updates land.
    always @(posedge i_clk) begin : result_check
        t_slice_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_slices.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result with no prediction waiting, process_index %0d",
                             $time, o_process_index);
            end else begin
                want = pending_slices.pop_front();
                check_field("process_index", 32'(want.process_index), 32'(o_process_index));
                check_field("slice_start", 32'(want.slice_start), 32'(o_slice_start));
                check_field("slice_end", 32'(want.slice_end), 32'(o_slice_end));
                check_field("finished", 32'(want.finished), 32'(o_finished));
                check_field("turnaround", 32'(want.turnaround), 32'(o_turnaround));
                check_field("waiting", 32'(want.waiting), 32'(o_waiting));
                check_field("idle_jump", 32'(want.idle_jump), 32'(o_idle_jump));
                check_field("all_done", 32'(want.all_done), 32'(o_all_done));
            end
        end
    end

    // Receiver. It stalls at random at the rate of the current phase. When a hold-off is
    // requested it keeps stall high for the whole hold-off, so that finished runs back up
    // and the block stalls its input while the sender keeps offering.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served < hold_requests) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_served++;
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: any handshake or register access counts as progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("round_robin_slice_scheduler verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus. After the opening script, each random phase waits for the block to go idle,
    // picks a quantum and slot count, and then usually loads every active slot in a shuffled
    // order before asking for slices. Now and then a phase keeps the old tables and only
    // changes the registers, which can leave the scan pointer past the active slots. Loads
    // scattered among the run transactions break schedules in mid flight. A slot is never
    // scanned before it has been loaded.
    initial begin
        int          row;
        int          phase;
        int          n;
        int          q;
        int          runs;
        int          j;
        int          pick;
        int          swap_slot;
        int          bmax;
        bit          all_loaded;
        int          order [MAX_PROCS];
        t_sched_item item;

        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        i_in_valid     <= 1'b0;
        i_op           <= rrss_pkg::OP_LOAD;
        i_slot_index   <= '0;
        i_burst_time   <= '0;
        i_arrival_time <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < NUM_SCRIPT_ROWS; row++) begin
            if (OPENING_SCRIPT[row].kind == ROW_CONFIG) begin
                settle();
                write_register(OPENING_SCRIPT[row].reg_index,
                               {20'd0, OPENING_SCRIPT[row].reg_value});
            end else begin
                send_item(OPENING_SCRIPT[row].item, OPENING_SCRIPT[row].typed,
                          OPENING_SCRIPT[row].slice);
            end
        end

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            settle();
            sender_idle_pct = SEND_IDLE_PCT[phase % 4];
            recv_stall_pct = RECV_STALL_PCT[phase % 4];

            // The first two phases pin the register extremes; later ones mostly use short
            // quanta so that slots take several turns each.
            if (phase == 0) begin
                q = 1;
                n = MAX_PROCS;
            end else if (phase == 1) begin
                q = 4095;
                n = 1;
            end else begin
                q = ($urandom_range(3) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 12);
                n = ($urandom_range(4) == 0) ? MAX_PROCS : $urandom_range(1, MAX_PROCS);
            end
            write_register(rrss_pkg::REG_QUANTUM, 32'(q));
            write_register(rrss_pkg::REG_COUNT, 32'(n));
            bmax = (q > 20) ? 4095 : 3 * q + 2;

            all_loaded = 1'b1;
            for (j = 0; j < n; j++)
                if (!slot_loaded[j])
                    all_loaded = 1'b0;

            if (!all_loaded || phase < 2 || $urandom_range(3) != 0) begin
                for (j = 0; j < n; j++)
                    order[j] = j;
                for (j = n - 1; j > 0; j--) begin
                    pick = $urandom_range(j);
                    swap_slot = order[j];
                    order[j] = order[pick];
                    order[pick] = swap_slot;
                end
                for (j = 0; j < n; j++)
                    send_item(make_load(order[j], bmax, 40), 1'b0, '0);
            end

            if (phase == 2)
                hold_requests++;

            runs = $urandom_range(n + 2, 3 * n + 10);
            for (j = 0; j < runs; j++) begin
                if ($urandom_range(9) == 0) begin
                    send_item(make_load($urandom_range(MAX_PROCS - 1), bmax, 40), 1'b0, '0);
                end else begin
                    // The payload fields of a run transaction are ignored; keep them busy.
                    item.op = rrss_pkg::OP_RUN;
                    item.slot_index = PIDX_W'($urandom);
                    item.burst_time = TIME_W'($urandom);
                    item.arrival_time = TIME_W'($urandom);
                    send_item(item, 1'b0, '0);
                end
            end
            phase++;
        end

        settle();
        if (fail_count == 0)
            $display("round_robin_slice_scheduler verification clean");
        else
            $display("round_robin_slice_scheduler verification failed");
        $finish;
    end

endmodule
